### design/edcs_pkg.sv
// Shared types and constants for the entity distance classifier.
// No dependencies; imported by every module of the block.
package edcs_pkg;

   localparam int COORD_W     = 17;
   localparam int MAG_W       = 17;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int DIST_W      = 36;
   localparam int COUNT_W     = 9;
   localparam int DROP_W      = 16;
   localparam int GEN_W       = 32;
   localparam int NUM_KINDS   = 4;
   localparam int REQ_DATA_W  = 56;
   localparam int RSP_DATA_W  = 208;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [COUNT_W-1:0] MAX_ENTITIES     = 9'd256;
   localparam logic [DROP_W-1:0]  DROP_SATURATE    = 16'hFFFF;
   localparam logic [DIST_W-1:0]  NEAREST_SENTINEL = 36'd51538821123;
   localparam logic [DIST_W-1:0]  THRESH_NEAR      = 36'd1048576;
   localparam logic [DIST_W-1:0]  THRESH_MID       = 36'd4194304;
   localparam logic [DIST_W-1:0]  THRESH_FAR       = 36'd37748736;

   typedef enum logic [1:0] {
      OP_BEGIN  = 2'd0,
      OP_PUSH   = 2'd1,
      OP_COMMIT = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CLASS_BEYOND = 2'd0,
      CLASS_FAR    = 2'd1,
      CLASS_MID    = 2'd2,
      CLASS_NEAR   = 2'd3
   } class_type;

   // One classified word handed from the front end to the statistics unit.
   typedef struct packed {
      logic [1:0]        op;
      logic [1:0]        kind;
      logic [DIST_W-1:0] sq_dist;
      logic [1:0]        cls;
   } entry_type;

endpackage

### design/entity_distance_classifier_stats.sv
// Top level of the entity distance classifier with frame statistics.
// Depends on edcs_pkg, edcs_front, edcs_queue and edcs_back.
//
// Usage:
//   req channel: one word per operation. tuser carries the operation
//   (begin frame, push entity, commit frame). A begin word latches the
//   camera origin from the coordinates and clears the frame statistics;
//   a push word carries an entity origin, effects flag and kind; a
//   commit word stamps the next frame generation.
//   rsp channel: exactly one word per request word, in order, with the
//   push result (stored flag, squared distance, priority class) and the
//   frame statistics as they stand after that word.
//   A word passes the front stage register, the queue and the output
//   register. Throughput: one word per cycle while rsp_tready stays
//   high; the front end subtracts and squares in one stage and sums
//   and classifies in the next; the statistics unit updates all counters.
//   A four-entry queue separates the front end from the statistics unit,
//   so a stalled receiver first fills the output register, then the
//   queue, then the front stage, and only then drops req_tready.
//   Reset (synchronous, active high) empties the pipeline and queue,
//   zeroes the camera and counters, sets nearest to its sentinel and the
//   next generation to one. No clearing pass is needed.
module entity_distance_classifier_stats import edcs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pos_x[16:0], pos_y[33:17], pos_z[50:34], has_effects[51],
   // entity_kind[53:52], zero pad[55:54]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // accepted[0], dist_sq[36:1], draw_class[38:37], count_stored[47:39],
   // count_dropped[63:48], count_alias[72:64], count_brush[81:73],
   // count_sprite[90:82], count_unknown[99:91], nearest_sq[135:100],
   // farthest_sq[171:136], frame_generation[203:172], zero pad[207:204]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic      fq_valid, fq_ready;
   entry_type fq_entry;
   logic      qb_valid, qb_ready;
   entry_type qb_entry;

   // Split the request word into its fields and hand it to the front end.
   edcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_op      (req_tuser),
      .in_x       (req_tdata[16:0]),
      .in_y       (req_tdata[33:17]),
      .in_z       (req_tdata[50:34]),
      .in_effects (req_tdata[51]),
      .in_kind    (req_tdata[53:52]),
      .out_valid  (fq_valid),
      .out_entry  (fq_entry),
      .out_ready  (fq_ready)
   );

   // Buffer classified words so each side can stall on its own.
   edcs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_ready (fq_ready),
      .wr_entry (fq_entry),
      .rd_valid (qb_valid),
      .rd_ready (qb_ready),
      .rd_entry (qb_entry)
   );

   // Apply each word to the statistics and register the response.
   edcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (qb_valid),
      .in_ready  (qb_ready),
      .in_entry  (qb_entry),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata)
   );

endmodule

### design/edcs_front.sv
// Front end: accepts request words, latches the camera, computes squared
// distance and priority class over two stages. Depends on edcs_pkg.
module edcs_front import edcs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [1:0]                in_op,
   input  logic signed [COORD_W-1:0] in_x,
   input  logic signed [COORD_W-1:0] in_y,
   input  logic signed [COORD_W-1:0] in_z,
   input  logic                      in_effects,
   input  logic [1:0]                in_kind,
   output logic                      out_valid,
   output entry_type                 out_entry,
   input  logic                      out_ready
);

   logic signed [COORD_W-1:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic                      s1_valid_ff, s1_valid_in;
   logic [1:0]                s1_op_ff, s1_kind_ff;
   logic                      s1_eff_ff;
   logic [SQ_W-1:0]           s1_sqx_ff, s1_sqy_ff, s1_sqz_ff;

   logic signed [COORD_W:0]   dx, dy, dz;
   logic [MAG_W-1:0]          mx, my, mz;
   logic [DIST_W-1:0]         dist_sum;
   logic [1:0]                cls;
   logic                      accept;

   assign in_ready = !s1_valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   // Subtract the camera and take the magnitude.
   always_comb begin
      dx = {in_x[COORD_W-1], in_x} - {cam_x_ff[COORD_W-1], cam_x_ff};
      dy = {in_y[COORD_W-1], in_y} - {cam_y_ff[COORD_W-1], cam_y_ff};
      dz = {in_z[COORD_W-1], in_z} - {cam_z_ff[COORD_W-1], cam_z_ff};
      mx = dx[COORD_W] ? MAG_W'(-dx) : MAG_W'(dx);
      my = dy[COORD_W] ? MAG_W'(-dy) : MAG_W'(dy);
      mz = dz[COORD_W] ? MAG_W'(-dz) : MAG_W'(dz);
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (out_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         cam_x_ff    <= '0;
         cam_y_ff    <= '0;
         cam_z_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept && in_op == OP_BEGIN) begin
            cam_x_ff <= in_x;
            cam_y_ff <= in_y;
            cam_z_ff <= in_z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff   <= in_op;
         s1_kind_ff <= in_kind;
         s1_eff_ff  <= in_effects;
         s1_sqx_ff  <= mx * mx;
         s1_sqy_ff  <= my * my;
         s1_sqz_ff  <= mz * mz;
      end
   end

   // Sum the squares and bin the distance; an effects flag forces the near class.
   always_comb begin
      dist_sum = DIST_W'(s1_sqx_ff) + DIST_W'(s1_sqy_ff) + DIST_W'(s1_sqz_ff);
      if (s1_eff_ff || dist_sum <= THRESH_NEAR) begin
         cls = CLASS_NEAR;
      end else if (dist_sum <= THRESH_MID) begin
         cls = CLASS_MID;
      end else if (dist_sum <= THRESH_FAR) begin
         cls = CLASS_FAR;
      end else begin
         cls = CLASS_BEYOND;
      end
   end

   assign out_valid         = s1_valid_ff;
   assign out_entry.op      = s1_op_ff;
   assign out_entry.kind    = s1_kind_ff;
   assign out_entry.sq_dist = dist_sum;
   assign out_entry.cls     = cls;

endmodule

### design/edcs_queue.sv
// Short queue of classified words between front end and statistics unit.
// Depends on edcs_pkg for the entry type and depth.
module edcs_queue import edcs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_valid,
   output logic      wr_ready,
   input  entry_type wr_entry,
   output logic      rd_valid,
   input  logic      rd_ready,
   output entry_type rd_entry
);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              push, pop;

   assign wr_ready = cnt_ff != (QPTR_W+1)'(QUEUE_DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign rd_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

### design/edcs_back.sv
// Statistics unit: applies each classified word to the frame statistics
// and holds the response word in an output register. Depends on edcs_pkg.
module edcs_back import edcs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  entry_type             in_entry,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [RSP_DATA_W-1:0] rsp_data
);

   logic [COUNT_W-1:0] stored_ff, stored_in;
   logic [DROP_W-1:0]  dropped_ff, dropped_in;
   logic [COUNT_W-1:0] kind_ff [NUM_KINDS];
   logic [COUNT_W-1:0] kind_in [NUM_KINDS];
   logic [DIST_W-1:0]  nearest_ff, nearest_in;
   logic [DIST_W-1:0]  farthest_ff, farthest_in;
   logic [GEN_W-1:0]   next_gen_ff, next_gen_in;
   logic [GEN_W-1:0]   last_gen_ff, last_gen_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic               acc;
   logic [DIST_W-1:0]  dist_out;
   logic [1:0]         cls_out;
   logic               take;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      stored_in   = stored_ff;
      dropped_in  = dropped_ff;
      kind_in     = kind_ff;
      nearest_in  = nearest_ff;
      farthest_in = farthest_ff;
      next_gen_in = next_gen_ff;
      last_gen_in = last_gen_ff;
      acc         = 1'b0;
      dist_out    = '0;
      cls_out     = CLASS_BEYOND;
      case (in_entry.op)
         OP_BEGIN: begin
            stored_in   = '0;
            dropped_in  = '0;
            for (int k = 0; k < NUM_KINDS; k++) begin
               kind_in[k] = '0;
            end
            nearest_in  = NEAREST_SENTINEL;
            farthest_in = '0;
         end
         OP_PUSH: begin
            if (stored_ff >= MAX_ENTITIES) begin
               if (dropped_ff != DROP_SATURATE) begin
                  dropped_in = dropped_ff + 1'b1;
               end
            end else begin
               stored_in = stored_ff + 1'b1;
               if (in_entry.sq_dist < nearest_ff) begin
                  nearest_in = in_entry.sq_dist;
               end
               if (in_entry.sq_dist > farthest_ff) begin
                  farthest_in = in_entry.sq_dist;
               end
               kind_in[in_entry.kind] = kind_ff[in_entry.kind] + 1'b1;
               acc      = 1'b1;
               dist_out = in_entry.sq_dist;
               cls_out  = in_entry.cls;
            end
         end
         OP_COMMIT: begin
            if (stored_ff == '0) begin
               nearest_in = '0;
            end
            last_gen_in = next_gen_ff;
            next_gen_in = next_gen_ff + 1'b1;
         end
         default: begin
            // unused operation: report statistics only
         end
      endcase
   end

   always_comb begin
      rsp_data_in = {4'b0, last_gen_in, farthest_in, nearest_in,
                     kind_in[3], kind_in[2], kind_in[1], kind_in[0],
                     dropped_in, stored_in, cls_out, dist_out, acc};
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff    <= '0;
         dropped_ff   <= '0;
         for (int k = 0; k < NUM_KINDS; k++) begin
            kind_ff[k] <= '0;
         end
         nearest_ff   <= NEAREST_SENTINEL;
         farthest_ff  <= '0;
         next_gen_ff  <= GEN_W'(1);
         last_gen_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            stored_ff   <= stored_in;
            dropped_ff  <= dropped_in;
            kind_ff     <= kind_in;
            nearest_ff  <= nearest_in;
            farthest_ff <= farthest_in;
            next_gen_ff <= next_gen_in;
            last_gen_ff <= last_gen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
